// ===== rtl/core/edge_gradient_magnitude_assert.svh =====
// assertion macros for the checker of this block
`ifndef EDGE_GRADIENT_MAGNITUDE_ASSERT_SVH
`define EDGE_GRADIENT_MAGNITUDE_ASSERT_SVH

// checked only while out of reset
`define EGM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define EGM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/egm_pkg.sv =====
`default_nettype none

package egm_pkg;

    localparam int MAX_WIDTH    = 2048;
    localparam int COL_W        = 11;
    localparam int ROW_W        = 16;
    localparam int LW_W         = 12;
    localparam int CFG_W        = 16;
    localparam int CFG_IDX_W    = 1;
    localparam int NCHAN        = 3;
    localparam int MAG_W        = 8;
    localparam int RAD_W        = 16;
    localparam int REM_W        = 11;
    localparam int ROOT_STAGES  = 4;
    localparam int ROOT_STEPS   = 2;

    localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic [LW_W-1:0]  LINE_WIDTH_RESET   = 12'd640;
    localparam logic [ROW_W-1:0] FRAME_HEIGHT_RESET = 16'd480;
    localparam logic [MAG_W-1:0] MAG_MAX            = 8'd255;

    typedef struct packed {
        logic [7:0] in_alpha;
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
    } pixel_t;

    typedef struct packed {
        logic [7:0]       out_alpha;
        logic [7:0]       out_red;
        logic [7:0]       out_green;
        logic [7:0]       out_blue;
        logic [COL_W-1:0] out_column;
        logic [ROW_W-1:0] out_row;
        logic             frame_done;
    } result_t;

    // sideband that rides along the magnitude pipeline
    typedef struct packed {
        logic [7:0]       alpha;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             done;
    } meta_t;

    // digit recurrence state of one channel's square root
    typedef struct packed {
        logic             sat;
        logic [RAD_W-1:0] val;
        logic [REM_W-1:0] rem;
        logic [MAG_W-1:0] root;
    } root_t;

    function automatic logic [15:0] square8(input logic [7:0] a);
        return 16'(a) * 16'(a);
    endfunction

    // one result bit of floor(sqrt) per call, two radicand bits consumed
    function automatic root_t root_step(input root_t r);
        logic [REM_W-1:0] rem_sh;
        logic [REM_W-1:0] trial;
        root_t            n;
        rem_sh = {r.rem[REM_W-3:0], r.val[RAD_W-1:RAD_W-2]};
        trial  = {1'b0, r.root, 2'b01};
        n      = r;
        n.val  = {r.val[RAD_W-3:0], 2'b00};
        if (rem_sh >= trial)
        begin
            n.rem  = rem_sh - trial;
            n.root = {r.root[MAG_W-2:0], 1'b1};
        end
        else
        begin
            n.rem  = rem_sh;
            n.root = {r.root[MAG_W-2:0], 1'b0};
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/egm_root.sv =====
`default_nettype none

module egm_root import egm_pkg::*; (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  root_t [NCHAN-1:0]            in_root,
    input  meta_t                        in_meta,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [NCHAN-1:0][MAG_W-1:0]  out_mag,
    output meta_t                        out_meta
);

    logic             stg_valid_reg [ROOT_STAGES];
    root_t [NCHAN-1:0] stg_root_reg [ROOT_STAGES];
    meta_t            stg_meta_reg  [ROOT_STAGES];
    logic [ROOT_STAGES:0] stg_ready;

    assign stg_ready[ROOT_STAGES] = out_ready;

    for (genvar s = 0; s < ROOT_STAGES; s++)
    begin : g_stage
        logic              vin;
        root_t [NCHAN-1:0] rin;
        root_t [NCHAN-1:0] root_next;
        meta_t             min;

        if (s == 0)
        begin : g_first
            assign vin = in_valid;
            assign rin = in_root;
            assign min = in_meta;
        end
        else
        begin : g_rest
            assign vin = stg_valid_reg[s-1];
            assign rin = stg_root_reg[s-1];
            assign min = stg_meta_reg[s-1];
        end

        assign stg_ready[s] = !stg_valid_reg[s] || stg_ready[s+1];

        always_comb
        begin
            root_t t;
            for (int c = 0; c < NCHAN; c++)
            begin
                t = rin[c];
                for (int j = 0; j < ROOT_STEPS; j++)
                begin
                    t = root_step(t);
                end
                root_next[c] = t;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                stg_valid_reg[s] <= 1'b0;
            end
            else if (stg_ready[s])
            begin
                stg_valid_reg[s] <= vin;
            end
        end

        always_ff @(posedge clk)
        begin
            if (stg_ready[s])
            begin
                stg_root_reg[s] <= root_next;
                stg_meta_reg[s] <= min;
            end
        end
    end

    assign in_ready  = stg_ready[0];
    assign out_valid = stg_valid_reg[ROOT_STAGES-1];
    assign out_meta  = stg_meta_reg[ROOT_STAGES-1];

    // clamp: a saturated radicand always gives the maximum
    always_comb
    begin
        for (int c = 0; c < NCHAN; c++)
        begin
            out_mag[c] = stg_root_reg[ROOT_STAGES-1][c].sat ? MAG_MAX
                                                          : stg_root_reg[ROOT_STAGES-1][c].root;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/edge_gradient_magnitude.sv =====
`default_nettype none

// forward difference gradient magnitude over a raster ARGB pixel stream.
// pixels enter one per clock; the block keeps the previous row in a line
// memory of MAX_WIDTH words. the result for pixel (r, c) is produced when
// pixel (r+1, c) arrives: per color channel floor(2*sqrt(dx^2 + dy^2))
// clamped to 255, with dx and dy the differences to the right and lower
// neighbor; alpha of the center pixel passes through. the first incoming
// row and the last column of each row produce no result, so each frame of
// W x H pixels gives (W-1) x (H-1) results, frame_done marking the last.
// throughput is one pixel per clock unless either side stalls; the stages
// are line memory read, squaring, sum, four square root stages of two
// result bits each, and the output register. the line memory does one
// write and one read per pixel, which is what sets the one pixel per
// clock figure. writing either config register restarts the frame at row
// 0, column 0; write config only while no pixel is in flight.
// a line_width below 2 acts as 2, above MAX_WIDTH as MAX_WIDTH; a
// frame_height below 2 acts as 2. the line memory needs no clearing: a
// word is only used after the current frame's first row has written it.
module edge_gradient_magnitude import egm_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    // config write port
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    // pixel input channel
    input  logic                 pix_valid,
    output logic                 pix_stall,
    input  pixel_t               pix_data,
    // result output channel
    output logic                 res_valid,
    input  logic                 res_stall,
    output result_t              res_data
);

    // ------------------------------------------------------------------
    // config registers
    // ------------------------------------------------------------------
    logic [LW_W-1:0]  line_width_reg;
    logic [ROW_W-1:0] frame_height_reg;
    logic [LW_W-1:0]  width_eff;
    logic [ROW_W-1:0] height_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg   <= LINE_WIDTH_RESET;
            frame_height_reg <= FRAME_HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_LINE_WIDTH:   line_width_reg   <= cfg_data[LW_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[ROW_W-1:0];
            endcase
        end
    end

    // out of range settings fold to the nearest legal size
    always_comb
    begin
        priority if (line_width_reg < LW_W'(2))
            width_eff = LW_W'(2);
        else if (line_width_reg > LW_W'(MAX_WIDTH))
            width_eff = LW_W'(MAX_WIDTH);
        else
            width_eff = line_width_reg;
        height_eff = (frame_height_reg < ROW_W'(2)) ? ROW_W'(2) : frame_height_reg;
    end

    // ------------------------------------------------------------------
    // handshake chain: each stage loads when it is empty or moves on
    // ------------------------------------------------------------------
    logic out_ready;
    logic root_in_ready;
    logic s1_ready;
    logic s2_ready;
    logic s3_ready;
    logic pix_xfer;

    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s3_valid_reg;
    logic res_valid_reg;

    assign out_ready = !res_valid_reg || !res_stall;
    assign s3_ready  = !s3_valid_reg || root_in_ready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign pix_stall = !s1_ready;
    assign pix_xfer  = pix_valid && s1_ready;

    // ------------------------------------------------------------------
    // position counters of the next incoming pixel
    // ------------------------------------------------------------------
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    logic [LW_W-1:0]  col_ext;
    logic             last_col;
    logic             last_row;
    logic             emit;
    logic             done;
    logic [COL_W-1:0] rd_addr;

    assign col_ext  = {1'b0, col_reg};
    assign last_col = (col_ext + LW_W'(1)) == width_eff;
    assign last_row = row_reg == (height_eff - ROW_W'(1));
    // no result from the first row or the last column
    assign emit     = (row_reg != '0) && !last_col;
    assign done     = last_row && (col_ext == (width_eff - LW_W'(2)));
    // read the right neighbor; at the row end fetch word 0, the center of
    // the first result of the next row
    assign rd_addr  = last_col ? '0 : col_reg + COL_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cfg_write)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (pix_xfer)
        begin
            if (last_col)
            begin
                col_reg <= '0;
                row_reg <= last_row ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_reg <= col_reg + COL_W'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 1: line memory write and read
    // ------------------------------------------------------------------
    pixel_t           line_mem [MAX_WIDTH];
    pixel_t           s1_right_reg;
    pixel_t           s1_centre_reg;
    pixel_t           s1_pix_reg;
    logic             s1_emit_reg;
    logic             s1_done_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic [ROW_W-1:0] s1_row_reg;

    // the right word of one pixel is the center word of the next transfer
    always_ff @(posedge clk)
    begin
        if (pix_xfer)
        begin
            line_mem[col_reg] <= pix_data;
            s1_right_reg      <= line_mem[rd_addr];
            s1_centre_reg     <= s1_right_reg;
            s1_pix_reg        <= pix_data;
            s1_emit_reg       <= emit;
            s1_done_reg       <= done;
            s1_col_reg        <= col_reg;
            s1_row_reg        <= row_reg - ROW_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= pix_valid;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: absolute differences and squares
    // ------------------------------------------------------------------
    logic [7:0]  cen_ch [NCHAN];
    logic [7:0]  rgt_ch [NCHAN];
    logic [7:0]  low_ch [NCHAN];
    logic [15:0] sqx_next [NCHAN];
    logic [15:0] sqy_next [NCHAN];
    logic [15:0] s2_sqx_reg [NCHAN];
    logic [15:0] s2_sqy_reg [NCHAN];
    meta_t       s2_meta_reg;

    always_comb
    begin
        logic [7:0] dx;
        logic [7:0] dy;
        cen_ch[0] = s1_centre_reg.in_red;
        cen_ch[1] = s1_centre_reg.in_green;
        cen_ch[2] = s1_centre_reg.in_blue;
        rgt_ch[0] = s1_right_reg.in_red;
        rgt_ch[1] = s1_right_reg.in_green;
        rgt_ch[2] = s1_right_reg.in_blue;
        low_ch[0] = s1_pix_reg.in_red;
        low_ch[1] = s1_pix_reg.in_green;
        low_ch[2] = s1_pix_reg.in_blue;
        for (int k = 0; k < NCHAN; k++)
        begin
            dx = (cen_ch[k] >= rgt_ch[k]) ? cen_ch[k] - rgt_ch[k] : rgt_ch[k] - cen_ch[k];
            dy = (cen_ch[k] >= low_ch[k]) ? cen_ch[k] - low_ch[k] : low_ch[k] - cen_ch[k];
            sqx_next[k] = square8(dx);
            sqy_next[k] = square8(dy);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready)
        begin
            s2_sqx_reg        <= sqx_next;
            s2_sqy_reg        <= sqy_next;
            s2_meta_reg.alpha <= s1_centre_reg.in_alpha;
            s2_meta_reg.col   <= s1_col_reg;
            s2_meta_reg.row   <= s1_row_reg;
            s2_meta_reg.done  <= s1_done_reg;
        end
    end

    // pixels that give no result leave the pipeline here
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            s2_valid_reg <= s1_valid_reg && s1_emit_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: sum of squares, times four, saturation check
    // ------------------------------------------------------------------
    root_t [NCHAN-1:0] root_next;
    root_t [NCHAN-1:0] s3_root_reg;
    meta_t             s3_meta_reg;

    // 4*s >= 65536 means a root of at least 256, which clamps anyway
    always_comb
    begin
        logic [16:0] sum;
        for (int k = 0; k < NCHAN; k++)
        begin
            sum               = 17'(s2_sqx_reg[k]) + 17'(s2_sqy_reg[k]);
            root_next[k].sat  = |sum[16:14];
            root_next[k].val  = {sum[13:0], 2'b00};
            root_next[k].rem  = '0;
            root_next[k].root = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_ready)
        begin
            s3_root_reg <= root_next;
            s3_meta_reg <= s2_meta_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (s3_ready)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // stages 4 to 7: pipelined integer square root
    // ------------------------------------------------------------------
    logic                        root_valid;
    logic [NCHAN-1:0][MAG_W-1:0] root_mag;
    meta_t                       root_meta;

    egm_root u_root (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s3_valid_reg),
        .in_ready  (root_in_ready),
        .in_root   (s3_root_reg),
        .in_meta   (s3_meta_reg),
        .out_valid (root_valid),
        .out_ready (out_ready),
        .out_mag   (root_mag),
        .out_meta  (root_meta)
    );

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    result_t res_reg;

    always_ff @(posedge clk)
    begin
        if (out_ready)
        begin
            res_reg.out_alpha  <= root_meta.alpha;
            res_reg.out_red    <= root_mag[0];
            res_reg.out_green  <= root_mag[1];
            res_reg.out_blue   <= root_mag[2];
            res_reg.out_column <= root_meta.col;
            res_reg.out_row    <= root_meta.row;
            res_reg.frame_done <= root_meta.done;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            res_valid_reg <= root_valid;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

endmodule

`default_nettype wire

// ===== rtl/core/egm_check.sv =====
`default_nettype none

`include "edge_gradient_magnitude_assert.svh"

module egm_check import egm_pkg::*; (
    input logic    clk,
    input logic    rst_n,
    input logic    pix_stall,
    input logic    res_valid,
    input logic    res_stall,
    input result_t res_data
);

    // nothing comes out while in reset
    `EGM_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> !res_valid, "result valid during reset")

    // a stalled result holds until transferred
    `EGM_ASSERT(a_res_hold, res_valid && res_stall |=> res_valid && $stable(res_data), "stalled result changed")

    // an empty output register leaves the whole pipeline free to take pixels
    `EGM_ASSERT(a_no_idle_stall, !res_valid |-> !pix_stall, "pixel stalled with empty output")

    // column 2047, the last one at MAX_WIDTH, never produces a result
    `EGM_ASSERT(a_col_range, res_valid |-> res_data.out_column != '1, "result column out of range")

endmodule

bind edge_gradient_magnitude egm_check u_egm_check (.*);

`default_nettype wire

// ===== test/edge_gradient_magnitude_tb.sv =====
module edge_gradient_magnitude_tb;
    import egm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // run limits in clock cycles
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int DRAIN_LIMIT   = 20_000;
    // pipeline is 8 deep, leave some slack before touching config
    localparam int SETTLE_CYCLES = 12;
    localparam int REPORT_LINES  = 40;

    // ------------------------------------------------------------------
    // predictor and queue of expected gradient results
    // ------------------------------------------------------------------
    class magnitude_scoreboard;
        logic [LW_W-1:0]  line_width;
        logic [ROW_W-1:0] frame_height;
        pixel_t           line_store [MAX_WIDTH];
        int               column;
        int               row;
        result_t          pending_results [$];
        int               errors;
        int               pixels_seen;
        int               results_seen;

        function new();
            line_width   = LINE_WIDTH_RESET;
            frame_height = FRAME_HEIGHT_RESET;
            column       = 0;
            row          = 0;
            errors       = 0;
            pixels_seen  = 0;
            results_seen = 0;
            foreach (line_store[i])
                line_store[i] = '0;
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= REPORT_LINES)
                $display("error at %0t ns: %s", $time, msg);
        endfunction

        // any register write also restarts the frame
        function void set_register(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] value);
            if (index == REG_LINE_WIDTH)
                line_width = value[LW_W-1:0];
            else if (index == REG_FRAME_HEIGHT)
                frame_height = value[ROW_W-1:0];
            else
                return;
            column = 0;
            row    = 0;
        endfunction

        // floor(2*sqrt(dx^2 + dy^2)) as isqrt(4*(dx^2 + dy^2)), clamped
        function logic [7:0] channel_magnitude(logic [7:0] centre, logic [7:0] right,
                                               logic [7:0] lower);
            int dx;
            int dy;
            int radicand;
            int root;
            int trial;
            dx       = int'(centre) - int'(right);
            dy       = int'(centre) - int'(lower);
            radicand = 4 * (dx * dx + dy * dy);
            root     = 0;
            // radicand stays below 2^20, so ten root bits are enough
            for (int b = 9; b >= 0; b--)
            begin
                trial = root | (1 << b);
                if (trial * trial <= radicand)
                    root = trial;
            end
            return (root > 255) ? MAG_MAX : 8'(root);
        endfunction

        function void note_pixel(pixel_t pix);
            int      w;
            int      h;
            int      col;
            int      rw;
            pixel_t  centre;
            pixel_t  right;
            result_t want;

            // out of range sizes are pinned to the legal window
            if (line_width < 2)
                w = 2;
            else if (line_width > MAX_WIDTH)
                w = MAX_WIDTH;
            else
                w = int'(line_width);
            h   = (frame_height < 2) ? 2 : int'(frame_height);
            col = (column >= w) ? w - 1 : column;
            rw  = (row >= h) ? h - 1 : row;
            pixels_seen++;

            // first row and last column only fill the line store
            if (rw >= 1 && col + 1 < w)
            begin
                centre          = line_store[col];
                right           = line_store[col + 1];
                want.out_alpha  = centre.in_alpha;
                want.out_red    = channel_magnitude(centre.in_red, right.in_red, pix.in_red);
                want.out_green  = channel_magnitude(centre.in_green, right.in_green,
                                                    pix.in_green);
                want.out_blue   = channel_magnitude(centre.in_blue, right.in_blue, pix.in_blue);
                want.out_column = COL_W'(col);
                want.out_row    = ROW_W'(rw - 1);
                want.frame_done = (rw == h - 1 && col == w - 2);
                pending_results.push_back(want);
            end

            line_store[col] = pix;
            if (col + 1 >= w)
            begin
                column = 0;
                row    = (rw + 1 >= h) ? 0 : rw + 1;
            end
            else
            begin
                column = col + 1;
                row    = rw;
            end
        endfunction

        function void compare_field(string name, int got_value, int want_value,
                                    result_t want);
            if (got_value != want_value)
                report($sformatf("%s got %0d expected %0d (column %0d row %0d)", name,
                                 got_value, want_value, want.out_column, want.out_row));
        endfunction

        function void check_result(result_t got);
            result_t want;
            results_seen++;
            if (pending_results.size() == 0)
            begin
                report($sformatf("result with nothing pending (column %0d row %0d)",
                                 got.out_column, got.out_row));
                return;
            end
            want = pending_results.pop_front();
            compare_field("alpha", int'(got.out_alpha), int'(want.out_alpha), want);
            compare_field("red", int'(got.out_red), int'(want.out_red), want);
            compare_field("green", int'(got.out_green), int'(want.out_green), want);
            compare_field("blue", int'(got.out_blue), int'(want.out_blue), want);
            compare_field("column", int'(got.out_column), int'(want.out_column), want);
            compare_field("row", int'(got.out_row), int'(want.out_row), want);
            compare_field("frame_done", int'(got.frame_done), int'(want.frame_done), want);
        endfunction
    endclass

    // ------------------------------------------------------------------
    // clock, reset and block inputs, all known from time zero
    // ------------------------------------------------------------------
    logic                 clk;
    logic                 rst_n     = 1'b1;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_LINE_WIDTH;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 pix_valid = 1'b0;
    logic                 pix_stall;
    pixel_t               pix_data  = '0;
    logic                 res_valid;
    logic                 res_stall = 1'b0;
    result_t              res_data;

    magnitude_scoreboard board = new();

    int cycle_count    = 0;
    int settings_used  = 0;
    // when set, neither side inserts idle cycles
    bit calm           = 1'b0;
    int stall_left     = 0;
    int flow_left      = 0;

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    edge_gradient_magnitude dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix_data  (pix_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    // ------------------------------------------------------------------
    // idle lengths: mostly none or short, now and then a long one
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // mix of full random, saturating and gently varying pixels
    function automatic pixel_t make_pixel();
        pixel_t p;
        int     pick;
        p    = pixel_t'($urandom);
        pick = $urandom_range(0, 9);
        if (pick >= 8)
        begin
            p.in_red   = 8'd120 + 8'($urandom_range(0, 15));
            p.in_green = 8'd120 + 8'($urandom_range(0, 15));
            p.in_blue  = 8'd120 + 8'($urandom_range(0, 15));
        end
        else if (pick >= 6)
        begin
            p.in_red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            p.in_green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            p.in_blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end
        return p;
    endfunction

    // ------------------------------------------------------------------
    // monitor: transfers seen at the rising edge, before any update
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pix_valid && !pix_stall)
                board.note_pixel(pix_data);
            if (res_valid && !res_stall)
                board.check_result(res_data);
        end
    end

    // result side back-pressure, changed on the falling edge
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            res_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            res_stall <= 1'b0;
            if (flow_left > 0)
                flow_left--;
            else
            begin
                flow_left  = $urandom_range(0, 10);
                stall_left = pick_gap();
            end
        end
    end

    // hard stop in case the block hangs
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // drivers, entered and left on a falling edge
    // ------------------------------------------------------------------

    // one pixel transfer, with an optional idle gap in front
    task automatic send_pixel(input pixel_t p);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            pix_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pix_valid <= 1'b1;
        pix_data  <= p;
        // accepted at the first rising edge with stall low
        do
            @(posedge clk);
        while (pix_stall);
        @(negedge clk);
    endtask

    // width 2, height 2: centre, right, lower, then the unused corner
    task automatic send_quad(input pixel_t centre, input pixel_t right, input pixel_t lower);
        send_pixel(centre);
        send_pixel(right);
        send_pixel(lower);
        send_pixel(make_pixel());
    endtask

    // let every pending result drain, then give the pipeline time to empty
    task automatic settle();
        int waited;
        waited = 0;
        pix_valid <= 1'b0;
        while (board.pending_results.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        if (board.pending_results.size() != 0)
        begin
            board.report($sformatf("%0d results never arrived",
                                   board.pending_results.size()));
            board.pending_results.delete();
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        board.set_register(index, value);
    endtask

    // new frame geometry, only with the block idle
    task automatic apply_setting(input logic [CFG_W-1:0] width_value,
                                 input logic [CFG_W-1:0] height_value);
        settle();
        write_register(REG_LINE_WIDTH, width_value);
        write_register(REG_FRAME_HEIGHT, height_value);
        settings_used++;
        calm = ($urandom_range(0, 3) == 0);
    endtask

    task automatic run_setting(input logic [CFG_W-1:0] width_value,
                               input logic [CFG_W-1:0] height_value, input int count);
        apply_setting(width_value, height_value);
        repeat (count) send_pixel(make_pixel());
    endtask

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial
    begin
        // falling reset edge so every register starts known
        rst_n <= 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset geometry 640 x 480: part of the first row, nothing comes out
        repeat (20) send_pixel(make_pixel());

        // zero width and height act as 2: one result per four-pixel frame
        apply_setting(16'd0, 16'd0);
        calm = 1'b0;
        // full swing in both directions saturates every channel
        send_quad(pixel_t'(32'hFF_FF_00_FF), pixel_t'(32'h00_00_00_00),
                  pixel_t'(32'h00_00_FF_00));
        // negative differences, zero alpha
        send_quad(pixel_t'(32'h00_00_00_00), pixel_t'(32'h00_FF_FF_FF),
                  pixel_t'(32'hFF_FF_FF_FF));
        // smallest step, just under and just over the clamp
        send_quad(pixel_t'(32'h55_01_7F_80), pixel_t'(32'hAA_00_00_00),
                  pixel_t'(32'h00_01_7F_80));
        // mid-range magnitudes, including a non-integer root
        send_quad(pixel_t'(32'hAA_64_5A_C8), pixel_t'(32'h00_64_5D_C5),
                  pixel_t'(32'h00_00_5E_C5));
        // flat area gives zero
        send_quad(pixel_t'(32'h12_34_56_78), pixel_t'(32'h12_34_56_78),
                  pixel_t'(32'h12_34_56_78));
        // width and height of one also act as 2
        apply_setting(16'd1, 16'd1);
        send_quad(pixel_t'(32'h80_FE_01_7F), pixel_t'(32'h7F_FF_00_80),
                  pixel_t'(32'h01_FF_02_7E));

        // random part over small frames, each ending mid-frame
        run_setting(16'd5, 16'd3, 40);
        // bits above the width register are dropped: width 3
        run_setting(16'hF003, 16'd4, 40);
        run_setting(16'd7, 16'hFFFF, 40);
        run_setting(16'd2, 16'd2, 30);
        run_setting(16'd33, 16'd5, 60);
        run_setting(16'd1, 16'd9, 30);
        run_setting(16'd12, 16'd1, 30);
        run_setting(16'd20, 16'd3, 40);

        // 4095 acts as MAX_WIDTH: only the first row fills, nothing comes out
        run_setting(16'h0FFF, 16'd2, 40);
        // a longer line: a full row, then results from the second
        run_setting(16'd160, 16'hFFFF, 250);

        settle();
        $display("%0d pixel transfers in, %0d result transfers out",
                 board.pixels_seen, board.results_seen);
        $display("%0d frame geometries, widths 2 to 160 plus the %0d clamp, heights 2 to 65535",
                 settings_used + 1, MAX_WIDTH);
        if (board.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
